FILE: rtl/sma_pkg.sv
// Shared types and constants for the stroke moving average block.
package sma_pkg;

    localparam int SMA_WINDOW_DEF = 8;
    localparam int SMA_POS_W      = 20;
    localparam int SMA_ATTR_W     = 16;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_NEXT  = 1'b1
    } t_req_type;

    typedef struct packed {
        logic load;
        logic start;
        logic use_fill;
    } t_chan_ctrl;

endpackage

FILE: rtl/sma_req_if.sv
// Request channel carrying one pen sample.
interface sma_req_if import sma_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic signed [SMA_POS_W-1:0]  pos_x;
    logic signed [SMA_POS_W-1:0]  pos_y;
    logic        [SMA_ATTR_W-1:0] pressure;
    logic signed [SMA_ATTR_W-1:0] azimuth;
    logic signed [SMA_ATTR_W-1:0] altitude;
    logic        [SMA_ATTR_W-1:0] aux_value;

    modport source (output valid, req_type, pos_x, pos_y, pressure, azimuth, altitude,
                    aux_value, input ready);
    modport sink   (input valid, req_type, pos_x, pos_y, pressure, azimuth, altitude,
                    aux_value, output ready);
endinterface

FILE: rtl/sma_res_if.sv
// Result channel carrying the new and previous averages.
interface sma_res_if import sma_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [SMA_POS_W-1:0]  avg_x;
    logic signed [SMA_POS_W-1:0]  avg_y;
    logic        [SMA_ATTR_W-1:0] avg_pressure;
    logic signed [SMA_ATTR_W-1:0] avg_azimuth;
    logic signed [SMA_ATTR_W-1:0] avg_altitude;
    logic        [SMA_ATTR_W-1:0] avg_aux;
    logic signed [SMA_POS_W-1:0]  prev_x;
    logic signed [SMA_POS_W-1:0]  prev_y;
    logic        [SMA_ATTR_W-1:0] prev_pressure;
    logic signed [SMA_ATTR_W-1:0] prev_azimuth;
    logic signed [SMA_ATTR_W-1:0] prev_altitude;
    logic        [SMA_ATTR_W-1:0] prev_aux;

    modport source (output valid, avg_x, avg_y, avg_pressure, avg_azimuth, avg_altitude,
                    avg_aux, prev_x, prev_y, prev_pressure, prev_azimuth, prev_altitude,
                    prev_aux, input ready);
    modport sink   (input valid, avg_x, avg_y, avg_pressure, avg_azimuth, avg_altitude,
                    avg_aux, prev_x, prev_y, prev_pressure, prev_azimuth, prev_altitude,
                    prev_aux, output ready);
endinterface

FILE: rtl/stroke_moving_average_top.sv
// Top level of the six-channel pen stroke moving average filter.
// The block takes one request per cycle unless its output stalls, and delivers its result
// in the cycle after the request is accepted; the rate is set by the sum update in each
// channel and by the ring RAMs, which read the entry to be replaced in the cycle before.
// A start request loads the window with its sample without a clearing pass: per-entry
// valid bits mark the entries written since then; the others read as the start sample.
module stroke_moving_average_top import sma_pkg::*; #(
    parameter int WINDOW = SMA_WINDOW_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sma_req_if.sink   i_req,
    sma_res_if.source o_res
);

    localparam int K = $clog2(WINDOW);

    logic              r_out_valid;
    logic [K-1:0]      r_wp;
    logic [K-1:0]      n_wp;
    logic [WINDOW-1:0] r_vld;
    logic              ready;
    logic              accept;
    logic              start;
    t_chan_ctrl        ctrl;

    assign ready  = !r_out_valid || o_res.ready;
    assign accept = i_req.valid && ready;
    assign start  = (i_req.req_type == REQ_START);

    always_comb begin
        n_wp = r_wp;
        if (accept) begin
            n_wp = start ? '0 : r_wp + 1'b1;
        end
        ctrl.load     = accept;
        ctrl.start    = start;
        ctrl.use_fill = !r_vld[r_wp];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_wp        <= '0;
            r_vld       <= '0;
        end else begin
            r_wp <= n_wp;
            if (accept) begin
                r_out_valid <= 1'b1;
                if (start) begin
                    r_vld <= '0;
                end else begin
                    r_vld[r_wp] <= 1'b1;
                end
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_req.ready = ready;
    assign o_res.valid = r_out_valid;

    sma_chan #(.DATA_W(SMA_POS_W), .IS_SIGNED(1'b1), .WINDOW(WINDOW)) u_chan_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctrl (ctrl),
        .i_waddr (r_wp), .i_raddr (n_wp), .i_sample (i_req.pos_x),
        .o_avg (o_res.avg_x), .o_prev (o_res.prev_x)
    );

    sma_chan #(.DATA_W(SMA_POS_W), .IS_SIGNED(1'b1), .WINDOW(WINDOW)) u_chan_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctrl (ctrl),
        .i_waddr (r_wp), .i_raddr (n_wp), .i_sample (i_req.pos_y),
        .o_avg (o_res.avg_y), .o_prev (o_res.prev_y)
    );

    sma_chan #(.DATA_W(SMA_ATTR_W), .IS_SIGNED(1'b0), .WINDOW(WINDOW)) u_chan_pressure (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctrl (ctrl),
        .i_waddr (r_wp), .i_raddr (n_wp), .i_sample (i_req.pressure),
        .o_avg (o_res.avg_pressure), .o_prev (o_res.prev_pressure)
    );

    sma_chan #(.DATA_W(SMA_ATTR_W), .IS_SIGNED(1'b1), .WINDOW(WINDOW)) u_chan_azimuth (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctrl (ctrl),
        .i_waddr (r_wp), .i_raddr (n_wp), .i_sample (i_req.azimuth),
        .o_avg (o_res.avg_azimuth), .o_prev (o_res.prev_azimuth)
    );

    sma_chan #(.DATA_W(SMA_ATTR_W), .IS_SIGNED(1'b1), .WINDOW(WINDOW)) u_chan_altitude (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctrl (ctrl),
        .i_waddr (r_wp), .i_raddr (n_wp), .i_sample (i_req.altitude),
        .o_avg (o_res.avg_altitude), .o_prev (o_res.prev_altitude)
    );

    sma_chan #(.DATA_W(SMA_ATTR_W), .IS_SIGNED(1'b0), .WINDOW(WINDOW)) u_chan_aux (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctrl (ctrl),
        .i_waddr (r_wp), .i_raddr (n_wp), .i_sample (i_req.aux_value),
        .o_avg (o_res.avg_aux), .o_prev (o_res.prev_aux)
    );

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted request did not produce a pending result");

    a_start_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && start |=> r_wp == '0 && r_vld == '0)
        else $error("start request did not rewind the window");

    a_next_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !start |=> r_wp == K'($past(r_wp) + 1'b1))
        else $error("write pointer did not advance on a continue request");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_wp) && $stable(r_vld))
        else $error("window state changed without a request");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !ready |-> r_out_valid)
        else $error("request channel stalled with an empty result register");

endmodule

FILE: rtl/sma_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/sma_chan.sv
// One averaging channel: sample ring, running sum, fill value and result registers.
module sma_chan import sma_pkg::*; #(
    parameter int DATA_W    = 16,
    parameter bit IS_SIGNED = 1'b0,
    parameter int WINDOW    = SMA_WINDOW_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_chan_ctrl                i_ctrl,
    input  logic [$clog2(WINDOW)-1:0] i_waddr,
    input  logic [$clog2(WINDOW)-1:0] i_raddr,
    input  logic [DATA_W-1:0]         i_sample,
    output logic [DATA_W-1:0]         o_avg,
    output logic [DATA_W-1:0]         o_prev
);

    localparam int K     = $clog2(WINDOW);
    localparam int SUM_W = DATA_W + K;

    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  n_sum;
    logic [DATA_W-1:0] r_fill;
    logic [DATA_W-1:0] r_avg;
    logic [DATA_W-1:0] r_prev;
    logic [DATA_W-1:0] n_prev;
    logic [DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0] old_val;
    logic [SUM_W-1:0]  new_ext;
    logic [SUM_W-1:0]  old_ext;

    sma_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.load && !i_ctrl.start),
        .i_waddr (i_waddr),
        .i_wdata (i_sample),
        .i_raddr (i_raddr),
        .o_rdata (ram_rdata)
    );

    // Entries not written since the last start of stroke read as the start sample.
    always_comb begin
        old_val = i_ctrl.use_fill ? r_fill : ram_rdata;
        new_ext = {{K{IS_SIGNED && i_sample[DATA_W-1]}}, i_sample};
        old_ext = {{K{IS_SIGNED && old_val[DATA_W-1]}}, old_val};
        if (i_ctrl.start) begin
            n_sum  = {i_sample, {K{1'b0}}};
            n_prev = i_sample;
        end else begin
            n_sum  = r_sum + new_ext - old_ext;
            n_prev = r_sum[SUM_W-1:K];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_fill <= '0;
        end else if (i_ctrl.load) begin
            r_sum <= n_sum;
            if (i_ctrl.start) begin
                r_fill <= i_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_avg  <= n_sum[SUM_W-1:K];
            r_prev <= n_prev;
        end
    end

    assign o_avg  = r_avg;
    assign o_prev = r_prev;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the six-channel pen stroke moving average filter.
`timescale 1ns / 1ps

module testbench;
    import sma_pkg::*;

    localparam int WINDOW     = SMA_WINDOW_DEF;
    localparam int WIN_LOG2   = $clog2(WINDOW);
    localparam int CHANNELS   = 6;
    localparam int PAD        = SMA_POS_W - SMA_ATTR_W;
    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_SHOWN  = 10;

    localparam int    CHAN_W[CHANNELS]    = '{SMA_POS_W, SMA_POS_W, SMA_ATTR_W,
                                              SMA_ATTR_W, SMA_ATTR_W, SMA_ATTR_W};
    localparam string CHAN_NAME[CHANNELS] = '{"x", "y", "pressure", "azimuth",
                                              "altitude", "aux"};

    localparam logic signed [SMA_POS_W-1:0]  POS_MAX  = {1'b0, {(SMA_POS_W-1){1'b1}}};
    localparam logic signed [SMA_POS_W-1:0]  POS_MIN  = {1'b1, {(SMA_POS_W-1){1'b0}}};
    localparam logic signed [SMA_ATTR_W-1:0] ANG_MAX  = {1'b0, {(SMA_ATTR_W-1){1'b1}}};
    localparam logic signed [SMA_ATTR_W-1:0] ANG_MIN  = {1'b1, {(SMA_ATTR_W-1){1'b0}}};
    localparam logic        [SMA_ATTR_W-1:0] UNS_MAX  = {SMA_ATTR_W{1'b1}};

    typedef enum {SEND_STREAM, SEND_BURSTY} t_send_mode;
    typedef enum {STALL_NONE, STALL_BURSTY, STALL_HEAVY} t_stall_mode;

    typedef struct {
        t_req_type                    req_type;
        logic signed [SMA_POS_W-1:0]  pos_x;
        logic signed [SMA_POS_W-1:0]  pos_y;
        logic        [SMA_ATTR_W-1:0] pressure;
        logic signed [SMA_ATTR_W-1:0] azimuth;
        logic signed [SMA_ATTR_W-1:0] altitude;
        logic        [SMA_ATTR_W-1:0] aux_value;
    } t_pen_sample;

    // Each channel is held zero-extended to the widest field width.
    typedef struct packed {
        logic [CHANNELS-1:0][SMA_POS_W-1:0] avg;
        logic [CHANNELS-1:0][SMA_POS_W-1:0] prev;
    } t_pen_average;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sma_req_if req_if ();
    sma_res_if res_if ();

    stroke_moving_average_top #(
        .WINDOW (WINDOW)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    always #1 i_clk = ~i_clk;

    longint       chan_ring[CHANNELS][WINDOW];
    longint       chan_sum[CHANNELS];
    int unsigned  oldest_slot;
    t_pen_average pending_averages[$];

    t_send_mode  send_mode  = SEND_STREAM;
    t_stall_mode stall_mode = STALL_NONE;
    int          burst_left = 0;

    int mismatch_count  = 0;
    int requests_sent   = 0;
    int strokes_started = 0;
    int results_checked = 0;
    int idle_cycles     = 0;

    function automatic logic [SMA_POS_W-1:0] field_bits(longint v, int w);
        return SMA_POS_W'(v & ((longint'(1) << w) - 1));
    endfunction

    function automatic t_pen_average predict_averages(t_pen_sample s);
        t_pen_average res;
        longint       samp[CHANNELS];
        longint       prev_avg;
        samp[0] = longint'(s.pos_x);
        samp[1] = longint'(s.pos_y);
        samp[2] = longint'(s.pressure);
        samp[3] = longint'(s.azimuth);
        samp[4] = longint'(s.altitude);
        samp[5] = longint'(s.aux_value);
        for (int c = 0; c < CHANNELS; c++) begin
            if (s.req_type == REQ_START) begin
                for (int i = 0; i < WINDOW; i++) chan_ring[c][i] = samp[c];
                chan_sum[c] = samp[c] * WINDOW;
                prev_avg = samp[c];
            end else begin
                prev_avg = chan_sum[c] >>> WIN_LOG2;
                chan_sum[c] += samp[c] - chan_ring[c][oldest_slot];
                chan_ring[c][oldest_slot] = samp[c];
            end
            res.avg[c]  = field_bits(chan_sum[c] >>> WIN_LOG2, CHAN_W[c]);
            res.prev[c] = field_bits(prev_avg, CHAN_W[c]);
        end
        oldest_slot = (s.req_type == REQ_START) ? 0 : (oldest_slot + 1) % WINDOW;
        return res;
    endfunction

    function automatic longint rand_field(int w, bit is_signed);
        longint raw = longint'($urandom) & ((longint'(1) << w) - 1);
        longint top = longint'(1) << (w - 1);
        case ($urandom_range(0, 7))
            0: return is_signed ? top - 1 : (top << 1) - 1;
            1: return is_signed ? -top : 0;
            2: return is_signed ? longint'($urandom_range(0, 3)) - 2 : $urandom_range(0, 3);
            default: return (is_signed && raw >= top) ? raw - (top << 1) : raw;
        endcase
    endfunction

    function automatic t_pen_sample pen_sample(t_req_type t, longint x, longint y,
                                               longint p, longint az, longint al,
                                               longint aux);
        t_pen_sample s;
        s.req_type  = t;
        s.pos_x     = SMA_POS_W'(x);
        s.pos_y     = SMA_POS_W'(y);
        s.pressure  = SMA_ATTR_W'(p);
        s.azimuth   = SMA_ATTR_W'(az);
        s.altitude  = SMA_ATTR_W'(al);
        s.aux_value = SMA_ATTR_W'(aux);
        return s;
    endfunction

    function automatic t_pen_sample random_sample(t_req_type t);
        return pen_sample(t, rand_field(SMA_POS_W, 1'b1), rand_field(SMA_POS_W, 1'b1),
                          rand_field(SMA_ATTR_W, 1'b0), rand_field(SMA_ATTR_W, 1'b1),
                          rand_field(SMA_ATTR_W, 1'b1), rand_field(SMA_ATTR_W, 1'b0));
    endfunction

    task automatic note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic send_sample(t_pen_sample s);
        int gap;
        @(negedge i_clk);
        req_if.valid     <= 1'b1;
        req_if.req_type  <= s.req_type;
        req_if.pos_x     <= s.pos_x;
        req_if.pos_y     <= s.pos_y;
        req_if.pressure  <= s.pressure;
        req_if.azimuth   <= s.azimuth;
        req_if.altitude  <= s.altitude;
        req_if.aux_value <= s.aux_value;
        do @(posedge i_clk); while (!req_if.ready);
        requests_sent++;
        if (s.req_type == REQ_START) strokes_started++;
        if (send_mode == SEND_BURSTY) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 16);
                @(negedge i_clk);
                req_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_averages.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_strokes(int count);
        int sent = 0;
        int len;
        while (sent < count) begin
            send_sample(random_sample(REQ_START));
            sent++;
            len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3 * WINDOW);
            for (int i = 0; i < len && sent < count; i++) begin
                send_sample(random_sample(REQ_NEXT));
                sent++;
            end
        end
    endtask

    task automatic test_directed_extremes();
        send_mode  = SEND_STREAM;
        stall_mode = STALL_NONE;
        // Continue requests straight after reset work on the zeroed window.
        send_sample(pen_sample(REQ_NEXT, POS_MAX, POS_MAX, UNS_MAX, ANG_MAX, ANG_MAX,
                               UNS_MAX));
        send_sample(pen_sample(REQ_NEXT, POS_MIN, POS_MIN, 0, ANG_MIN, ANG_MIN, 0));
        send_sample(pen_sample(REQ_START, POS_MAX, POS_MAX, UNS_MAX, ANG_MAX, ANG_MAX,
                               UNS_MAX));
        // Sweep the full window from one extreme to the other and wrap the ring.
        repeat (WINDOW + 2)
            send_sample(pen_sample(REQ_NEXT, POS_MIN, POS_MIN, 0, ANG_MIN, ANG_MIN, 0));
        // A start in the middle of a stroke reloads the window and the oldest slot.
        send_sample(pen_sample(REQ_START, POS_MIN, POS_MIN, 0, ANG_MIN, ANG_MIN, 0));
        repeat (3)
            send_sample(pen_sample(REQ_NEXT, POS_MAX, POS_MAX, UNS_MAX, ANG_MAX, ANG_MAX,
                                   UNS_MAX));
        // Small negative sums check rounding toward minus infinity.
        send_sample(pen_sample(REQ_START, -1, -1, 1, -1, -1, 1));
        send_sample(pen_sample(REQ_NEXT, 0, 0, 0, 0, 0, 0));
        wait_for_drain();
    endtask

    task automatic test_back_to_back_strokes();
        send_mode  = SEND_STREAM;
        stall_mode = STALL_NONE;
        run_strokes(300);
        wait_for_drain();
    endtask

    task automatic test_bursty_traffic();
        send_mode  = SEND_BURSTY;
        stall_mode = STALL_BURSTY;
        burst_left = 0;
        run_strokes(350);
        wait_for_drain();
    endtask

    task automatic test_heavy_backpressure();
        send_mode  = SEND_STREAM;
        stall_mode = STALL_HEAVY;
        run_strokes(250);
        wait_for_drain();
    endtask

    initial begin
        bit level;
        int run_left;
        level        = 1'b1;
        run_left     = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_mode == STALL_NONE) begin
                res_if.ready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    level = ~level;
                    if (stall_mode == STALL_BURSTY)
                        run_left = level ? $urandom_range(1, 12) : $urandom_range(1, 6);
                    else
                        run_left = level ? $urandom_range(1, 2) : $urandom_range(4, 20);
                end
                run_left--;
                res_if.ready <= level;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_pen_sample  req_seen;
        t_pen_average want;
        t_pen_average got;
        bit           moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (req_if.valid && req_if.ready) begin
                req_seen.req_type  = t_req_type'(req_if.req_type);
                req_seen.pos_x     = req_if.pos_x;
                req_seen.pos_y     = req_if.pos_y;
                req_seen.pressure  = req_if.pressure;
                req_seen.azimuth   = req_if.azimuth;
                req_seen.altitude  = req_if.altitude;
                req_seen.aux_value = req_if.aux_value;
                pending_averages.insert(pending_averages.size(),
                                        predict_averages(req_seen));
                moved = 1'b1;
            end
            if (res_if.valid && res_if.ready) begin
                moved = 1'b1;
                got.avg  = {{{PAD{1'b0}}, res_if.avg_aux}, {{PAD{1'b0}}, res_if.avg_altitude},
                            {{PAD{1'b0}}, res_if.avg_azimuth},
                            {{PAD{1'b0}}, res_if.avg_pressure}, res_if.avg_y, res_if.avg_x};
                got.prev = {{{PAD{1'b0}}, res_if.prev_aux},
                            {{PAD{1'b0}}, res_if.prev_altitude},
                            {{PAD{1'b0}}, res_if.prev_azimuth},
                            {{PAD{1'b0}}, res_if.prev_pressure}, res_if.prev_y, res_if.prev_x};
                if (pending_averages.size() == 0) begin
                    note_mismatch("result arrived with no request outstanding");
                end else begin
                    want = pending_averages.pop_front();
                    results_checked++;
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (got.avg[c] !== want.avg[c])
                            note_mismatch($sformatf("avg_%s: expected %h, got %h",
                                          CHAN_NAME[c], want.avg[c], got.avg[c]));
                        if (got.prev[c] !== want.prev[c])
                            note_mismatch($sformatf("prev_%s: expected %h, got %h",
                                          CHAN_NAME[c], want.prev[c], got.prev[c]));
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("Timeout: no request or result moved for %0d cycles.", IDLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.req_type  = REQ_START;
        req_if.pos_x     = '0;
        req_if.pos_y     = '0;
        req_if.pressure  = '0;
        req_if.azimuth   = '0;
        req_if.altitude  = '0;
        req_if.aux_value = '0;
        oldest_slot      = 0;
        for (int c = 0; c < CHANNELS; c++) begin
            chan_sum[c] = 0;
            for (int i = 0; i < WINDOW; i++) chan_ring[c][i] = 0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_extremes();
        test_back_to_back_strokes();
        test_bursty_traffic();
        test_heavy_backpressure();

        repeat (5) @(posedge i_clk);
        if (pending_averages.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", pending_averages.size()));

        $display("Sent %0d requests in %0d strokes with a window of %0d samples.",
                 requests_sent, strokes_started, WINDOW);
        $display("Checked %0d results under streaming, bursty and heavy backpressure.",
                 results_checked);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches found.", mismatch_count);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: stroke_moving_average_top.f
rtl/sma_pkg.sv
rtl/sma_req_if.sv
rtl/sma_res_if.sv
rtl/sma_ram.sv
rtl/sma_chan.sv
rtl/stroke_moving_average_top.sv
tb/testbench.sv
